// ===== rtl/signature_interning_hash_table_macros.svh =====
// Assertion macros for the signature interning hash table.
// Taken in by the RTL files that carry assertions; needs clk_i and rst_ni in scope.
`ifndef SIGNATURE_INTERNING_HASH_TABLE_MACROS_SVH
`define SIGNATURE_INTERNING_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sih_pkg.sv =====
// Shared constants and types for the signature interning hash table.
// No dependencies; used by sih_mix and signature_interning_hash_table.
package sih_pkg;

  // Width of the class number and class count result fields
  localparam int FIELD_W = 10;

  // splitmix64 finalizer multipliers and shifts
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam int MIX_SHIFT_1 = 30;
  localparam int MIX_SHIFT_2 = 27;
  localparam int MIX_SHIFT_3 = 31;

  // Load limit is LOAD_NUM / LOAD_DEN of the slots
  localparam int LOAD_NUM = 3;
  localparam int LOAD_DEN = 5;

  // Top-level control states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CMP   = 5'b10000
  } sih_state_e;

endpackage

// ===== rtl/signature_interning_hash_table.sv =====
// Signature interning table: each beat on start_i/signature_i returns one result beat, strobed
// by done_o for a single cycle that cannot be held off, with the dense class number found or
// assigned. After reset the key memory is swept clean, one slot a cycle, while busy_o stays high.
// An item then passes through the shared 32x32 hash multiplier and is compared one slot per
// cycle through the key memory's single read port. An all-ones signature is answered in the
// cycle after it is accepted. A new item is accepted once busy_o is low, also in the cycle
// of done_o.
`include "signature_interning_hash_table_macros.svh"

module signature_interning_hash_table #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [63:0]                 signature_i,
  output logic                        done_o,
  output logic [sih_pkg::FIELD_W-1:0] class_num_o,
  output logic                        is_new_o,
  output logic                        table_full_o,
  output logic [sih_pkg::FIELD_W-1:0] classes_held_o
);

  localparam int IdxW  = $clog2(TABLE_SLOTS);
  localparam int CntW  = $clog2(TABLE_SLOTS + 1);
  localparam int Limit = (sih_pkg::LOAD_NUM * TABLE_SLOTS + sih_pkg::LOAD_DEN - 1)
                         / sih_pkg::LOAD_DEN;
  localparam int FW    = sih_pkg::FIELD_W;

  sih_pkg::sih_state_e state_q, state_d;

  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [CntW-1:0] tries_q, tries_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     key_q, key_d;
  logic            done_q, done_d;
  logic [FW-1:0]   class_num_q, class_num_d;
  logic            is_new_q, is_new_d;
  logic            full_q, full_d;
  logic [FW-1:0]   held_q, held_d;

  logic [63:0]     key_w;
  logic            accept_w;
  logic            mix_start;
  logic            mix_done;
  logic [63:0]     mix_hash;
  logic            at_limit;
  logic            ins_w;
  logic [IdxW-1:0] slot_inc;

  // Slot memories
  logic [63:0]     key_mem [TABLE_SLOTS];
  logic [CntW-1:0] id_mem  [TABLE_SLOTS];
  logic            key_we;
  logic            id_we;
  logic [IdxW-1:0] waddr;
  logic [63:0]     wkey;
  logic [IdxW-1:0] raddr;
  logic [63:0]     rd_key_q;
  logic [CntW-1:0] rd_id_q;

  assign key_w     = signature_i + 64'd1;
  assign accept_w  = start_i && (state_q == sih_pkg::ST_IDLE);
  assign mix_start = accept_w && (key_w != 64'd0);
  assign at_limit  = cnt_q >= CntW'(Limit);
  assign slot_inc  = IdxW'(slot_q + 1'b1);
  assign ins_w     = (state_q == sih_pkg::ST_CMP) && (rd_key_q == 64'd0) && !at_limit;

  sih_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .key_i   (key_w),
    .done_o  (mix_done),
    .hash_o  (mix_hash)
  );

  // Memory ports: sweep writes during clear, insert writes on a free slot.
  // The read runs one slot ahead while comparing, so each cycle probes a slot.
  assign key_we = (state_q == sih_pkg::ST_CLEAR) || ins_w;
  assign id_we  = ins_w;
  assign waddr  = (state_q == sih_pkg::ST_CLEAR) ? clr_q : slot_q;
  assign wkey   = (state_q == sih_pkg::ST_CLEAR) ? 64'd0 : key_q;
  assign raddr  = (state_q == sih_pkg::ST_CMP) ? slot_inc : slot_q;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= wkey;
    end
    rd_key_q <= key_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[waddr] <= cnt_q;
    end
    rd_id_q <= id_mem[raddr];
  end

  // Control and result next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    tries_d     = tries_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    done_d      = 1'b0;
    class_num_d = class_num_q;
    is_new_d    = is_new_q;
    full_d      = full_q;
    held_d      = held_q;
    unique case (state_q)
      sih_pkg::ST_CLEAR: begin
        clr_d = IdxW'(clr_q + 1'b1);
        if (&clr_q) begin
          state_d = sih_pkg::ST_IDLE;
        end
      end
      sih_pkg::ST_IDLE: begin
        if (start_i) begin
          key_d = key_w;
          if (key_w == 64'd0) begin
            // all-ones signature cannot be stored: answer at once
            done_d      = 1'b1;
            class_num_d = '0;
            is_new_d    = 1'b0;
            full_d      = 1'b0;
            held_d      = FW'(cnt_q);
          end else begin
            state_d = sih_pkg::ST_HASH;
          end
        end
      end
      sih_pkg::ST_HASH: begin
        if (mix_done) begin
          slot_d  = mix_hash[IdxW-1:0];
          tries_d = '0;
          state_d = sih_pkg::ST_READ;
        end
      end
      sih_pkg::ST_READ: begin
        state_d = sih_pkg::ST_CMP;
      end
      sih_pkg::ST_CMP: begin
        class_num_d = '0;
        is_new_d    = 1'b0;
        full_d      = 1'b0;
        held_d      = FW'(cnt_q);
        if (rd_key_q == 64'd0) begin
          // empty slot: insert unless at the load limit
          done_d  = 1'b1;
          state_d = sih_pkg::ST_IDLE;
          if (at_limit) begin
            full_d = 1'b1;
          end else begin
            class_num_d = FW'(cnt_q);
            is_new_d    = 1'b1;
            cnt_d       = CntW'(cnt_q + 1'b1);
            held_d      = FW'(cnt_d);
          end
        end else if (rd_key_q == key_q) begin
          done_d      = 1'b1;
          class_num_d = FW'(rd_id_q);
          state_d     = sih_pkg::ST_IDLE;
        end else if (tries_q == CntW'(TABLE_SLOTS - 1)) begin
          // whole table probed with no match and no free slot
          done_d  = 1'b1;
          full_d  = 1'b1;
          state_d = sih_pkg::ST_IDLE;
        end else begin
          slot_d  = slot_inc;
          tries_d = CntW'(tries_q + 1'b1);
        end
      end
      default: state_d = sih_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sih_pkg::ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    tries_q     <= tries_d;
    key_q       <= key_d;
    class_num_q <= class_num_d;
    is_new_q    <= is_new_d;
    full_q      <= full_d;
    held_q      <= held_d;
  end

  assign busy_o         = (state_q != sih_pkg::ST_IDLE);
  assign done_o         = done_q;
  assign class_num_o    = class_num_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;
  assign classes_held_o = held_q;

  // Checks
  `SIH_ASSERT_IMP(a_new_xor_full, done_o, !(is_new_o && table_full_o), "new and full together")
  `SIH_ASSERT_NEXT(a_cnt_step, ins_w, cnt_q == $past(cnt_q) + 1'b1, "class count missed insert")
  `SIH_ASSERT_IMP(a_full_at_limit, done_o && table_full_o, at_limit, "refused below load limit")
  `SIH_ASSERT_IMP(a_idle_no_write, state_q == sih_pkg::ST_IDLE, !key_we, "memory write when idle")
  `SIH_ASSERT_IMP(a_clear_busy, state_q == sih_pkg::ST_CLEAR, busy_o && !done_o, "beat during clear")

endmodule

// ===== rtl/sih_mix.sv =====
// splitmix64 finalizer on one shared 32x32 multiplier; a new key is taken only when not busy.
// Depends on sih_pkg for the mixing constants.
module sih_mix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  logic        busy_q;
  logic        round_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [63:0] h_q;
  logic [63:0] acc_q;
  logic [63:0] prod_q;
  logic [63:0] hash_q;

  logic [63:0] mul_c;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_d;
  logic [63:0] sum_w;

  // Low 64 bits of h * C as lo*lo + (lo*hi + hi*lo) << 32, one product per step
  assign mul_c  = round_q ? sih_pkg::MIX_MUL_B : sih_pkg::MIX_MUL_A;
  assign op_a   = (step_q == 2'd2) ? h_q[63:32] : h_q[31:0];
  assign op_b   = (step_q == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign prod_d = 64'(op_a) * 64'(op_b);
  assign sum_w  = acc_q + {prod_q[31:0], 32'd0};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= 1'b0;
      step_q  <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        round_q <= 1'b0;
        step_q  <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          if (round_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            round_q <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath: product register, accumulator, xor-shifts before, between and after the rounds
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i && !busy_q) begin
      h_q <= key_i ^ (key_i >> sih_pkg::MIX_SHIFT_1);
    end else if (busy_q) begin
      case (step_q)
        2'd1: acc_q <= prod_q;
        2'd2: acc_q <= sum_w;
        2'd3: begin
          if (!round_q) begin
            h_q <= sum_w ^ (sum_w >> sih_pkg::MIX_SHIFT_2);
          end else begin
            hash_q <= sum_w ^ (sum_w >> sih_pkg::MIX_SHIFT_3);
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign hash_o = hash_q;

endmodule
